/* design/odo_pkg.sv */
// ----------------------------------------------------------------------------
// odo_pkg
// Shared types, constants and functions for the wheel odometry tracker.
// ----------------------------------------------------------------------------
package odo_pkg;

	localparam int CORDIC_STEPS = 24;
	localparam int StepW        = 5;

	localparam logic [1:0] REG_DRIVE_RATIO = 2'd0;
	localparam logic [1:0] REG_SIDE_RATIO  = 2'd1;
	localparam logic [1:0] REG_TURN_GAIN   = 2'd2;

	localparam logic [31:0] DRIVE_RATIO_RST = 32'd983868;
	localparam logic [31:0] SIDE_RATIO_RST  = 32'd983868;
	localparam logic [47:0] TURN_GAIN_RST   = 48'd4479813392794;
	localparam logic signed [33:0] CORDIC_K = 34'sd652032874;

	typedef enum logic [4:0] {
		ST_IDLE, ST_MR, ST_ML, ST_MS, ST_TRAV, ST_H0, ST_H1, ST_H2, ST_HSUM,
		ST_CORD, ST_FLIP, ST_P0, ST_P1, ST_P2, ST_P3, ST_P4, ST_POS
	} odo_state_t;

	function automatic logic signed [33:0] atan_lut(input logic [StepW-1:0] i);
		logic signed [33:0] r;
		case (i)
			5'd0:  r = 34'sd536870912;
			5'd1:  r = 34'sd316933406;
			5'd2:  r = 34'sd167458907;
			5'd3:  r = 34'sd85004756;
			5'd4:  r = 34'sd42667331;
			5'd5:  r = 34'sd21354465;
			5'd6:  r = 34'sd10679838;
			5'd7:  r = 34'sd5340245;
			5'd8:  r = 34'sd2670163;
			5'd9:  r = 34'sd1335087;
			5'd10: r = 34'sd667544;
			5'd11: r = 34'sd333772;
			5'd12: r = 34'sd166886;
			5'd13: r = 34'sd83443;
			5'd14: r = 34'sd41722;
			5'd15: r = 34'sd20861;
			5'd16: r = 34'sd10430;
			5'd17: r = 34'sd5215;
			5'd18: r = 34'sd2608;
			5'd19: r = 34'sd1304;
			5'd20: r = 34'sd652;
			5'd21: r = 34'sd326;
			5'd22: r = 34'sd163;
			5'd23: r = 34'sd81;
			5'd24: r = 34'sd41;
			5'd25: r = 34'sd20;
			5'd26: r = 34'sd10;
			5'd27: r = 34'sd5;
			5'd28: r = 34'sd3;
			5'd29: r = 34'sd1;
			5'd30: r = 34'sd1;
			default: r = 34'sd0;
		endcase
		return r;
	endfunction

	// {hit, value}: saturate a wide signed value to 32 bits
	function automatic logic [32:0] sat32(input logic signed [49:0] v);
		logic [32:0] r;
		if (v > 50'sd2147483647) begin
			r = {1'b1, 32'h7FFF_FFFF};
		end else if (v < -50'sd2147483648) begin
			r = {1'b1, 32'h8000_0000};
		end else begin
			r = {1'b0, v[31:0]};
		end
		return r;
	endfunction

endpackage

/* design/odo_in_if.sv */
// ----------------------------------------------------------------------------
// odo_in_if
// Encoder count channel.
// ----------------------------------------------------------------------------
interface odo_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] right_count;
	logic signed [31:0] left_count;
	logic signed [31:0] side_count;
	modport source (output valid, right_count, left_count, side_count, input ready);
	modport sink (input valid, right_count, left_count, side_count, output ready);
endinterface

/* design/odo_out_if.sv */
// ----------------------------------------------------------------------------
// odo_out_if
// Pose result channel.
// ----------------------------------------------------------------------------
interface odo_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic [31:0]        angle;
	logic               clipped;
	modport source (output valid, pos_x, pos_y, angle, clipped, input ready);
	modport sink (input valid, pos_x, pos_y, angle, clipped, output ready);
endinterface

/* design/odo_cfg_if.sv */
// ----------------------------------------------------------------------------
// odo_cfg_if
// Register write channel.
// ----------------------------------------------------------------------------
interface odo_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [47:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* design/wheel_odometry_tracker_top.sv */
// One shared 33x33 multiplier and one iterative CORDIC stage carry all the
// arithmetic in turn; a new input is taken only in idle, once the last item
// has passed its position update.
// A finished result waits in the output register while the next item runs.
// Reset (arst_n low) clears counts, position, heading and loads default ratios.
// ----------------------------------------------------------------------------
// wheel_odometry_tracker_top
// Three-wheel tracking odometry with a sequenced multiplier and CORDIC.
// ----------------------------------------------------------------------------
module wheel_odometry_tracker_top
	import odo_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	odo_in_if.sink     in_ch,
	odo_out_if.source  out_ch,
	odo_cfg_if.sink    cfg_ch
);

	odo_state_t state_q, state_d;

	logic [31:0] drive_q, side_q;
	logic [47:0] gain_q;
	logic [31:0] prev_r_q, prev_l_q, prev_s_q;
	logic [31:0] x_q, y_q, head_q;
	logic signed [31:0] dr_q, dl_q, ds_q;
	logic signed [49:0] rt_q, lt_q;
	logic signed [31:0] a_q, s_q;
	logic [63:0] diff_q;
	logic [31:0] hstep_q;
	logic signed [33:0] cx_q, cy_q, z_q;
	logic flip_q;
	logic [StepW-1:0] step_q;
	logic signed [32:0] c_q, sn_q;
	logic signed [66:0] acc_q, dxs_q;
	logic signed [65:0] prod_q;
	logic signed [32:0] mul_a, mul_b;
	logic ovalid_q, oclip_q;
	logic [31:0] ox_q, oy_q, oang_q;

	logic in_fire, out_free;
	assign in_fire  = in_ch.valid && in_ch.ready;
	assign out_free = !ovalid_q || out_ch.ready;

	assign in_ch.ready  = (state_q == ST_IDLE);
	assign cfg_ch.ready = 1'b1;
	assign out_ch.valid   = ovalid_q;
	assign out_ch.pos_x   = ox_q;
	assign out_ch.pos_y   = oy_q;
	assign out_ch.angle   = oang_q;
	assign out_ch.clipped = oclip_q;

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_MR: begin mul_a = {dr_q[31], dr_q}; mul_b = {1'b0, drive_q}; end
			ST_ML: begin mul_a = {dl_q[31], dl_q}; mul_b = {1'b0, drive_q}; end
			ST_MS: begin mul_a = {ds_q[31], ds_q}; mul_b = {1'b0, side_q}; end
			ST_H0: begin mul_a = {1'b0, diff_q[31:0]};  mul_b = {1'b0, gain_q[31:0]}; end
			ST_H1: begin mul_a = {1'b0, diff_q[63:32]}; mul_b = {1'b0, gain_q[31:0]}; end
			ST_H2: begin mul_a = {1'b0, diff_q[31:0]};  mul_b = {17'd0, gain_q[47:32]}; end
			ST_P0: begin mul_a = {a_q[31], a_q}; mul_b = sn_q; end
			ST_P1: begin mul_a = {s_q[31], s_q}; mul_b = c_q; end
			ST_P2: begin mul_a = {a_q[31], a_q}; mul_b = c_q; end
			ST_P3: begin mul_a = {s_q[31], s_q}; mul_b = sn_q; end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_fire) state_d = ST_MR;
			ST_MR:   state_d = ST_ML;
			ST_ML:   state_d = ST_MS;
			ST_MS:   state_d = ST_TRAV;
			ST_TRAV: state_d = ST_H0;
			ST_H0:   state_d = ST_H1;
			ST_H1:   state_d = ST_H2;
			ST_H2:   state_d = ST_HSUM;
			ST_HSUM: state_d = ST_CORD;
			ST_CORD: if (step_q == StepW'(CORDIC_STEPS - 1)) state_d = ST_FLIP;
			ST_FLIP: state_d = ST_P0;
			ST_P0:   state_d = ST_P1;
			ST_P1:   state_d = ST_P2;
			ST_P2:   state_d = ST_P3;
			ST_P3:   state_d = ST_P4;
			ST_P4:   state_d = ST_POS;
			ST_POS:  if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// datapath combinational helpers
	logic signed [65:0] neg_prod;
	logic signed [50:0] tsum, tdiff;
	logic signed [50:0] tavg;
	logic [31:0] nhead;
	logic signed [31:0] nhead_s;
	logic [31:0] fold;
	logic signed [33:0] ysh, xsh, atv;
	logic signed [66:0] dx_w, dy_w;
	logic signed [49:0] nx, ny;
	logic [32:0] satx, saty, sata, sats;
	logic signed [65:0] st_w;

	always_comb begin
		neg_prod = -prod_q;
		st_w     = prod_q >>> 16;
		tsum     = 51'(rt_q) + 51'(lt_q);
		tdiff    = 51'(lt_q) - 51'(rt_q);
		tavg     = tsum >>> 1;
		sata     = sat32(tavg[49:0]);
		sats     = sat32(st_w[49:0]);
		nhead    = head_q + hstep_q + prod_q[31:0];
		nhead_s  = nhead;
		fold     = nhead - 32'h8000_0000;
		ysh      = cy_q >>> step_q;
		xsh      = cx_q >>> step_q;
		atv      = atan_lut(step_q);
		dx_w     = dxs_q >>> 30;
		dy_w     = acc_q >>> 30;
		nx       = 50'(signed'(x_q)) + dx_w[49:0];
		ny       = 50'(signed'(y_q)) + dy_w[49:0];
		satx     = sat32(nx);
		saty     = sat32(ny);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_q  <= DRIVE_RATIO_RST;
			side_q   <= SIDE_RATIO_RST;
			gain_q   <= TURN_GAIN_RST;
			prev_r_q <= '0;
			prev_l_q <= '0;
			prev_s_q <= '0;
			x_q      <= '0;
			y_q      <= '0;
			head_q   <= '0;
			ovalid_q <= 1'b0;
			step_q   <= '0;
		end else begin
			if (cfg_ch.valid) begin
				case (cfg_ch.index)
					REG_DRIVE_RATIO: drive_q <= cfg_ch.data[31:0];
					REG_SIDE_RATIO:  side_q  <= cfg_ch.data[31:0];
					REG_TURN_GAIN:   gain_q  <= cfg_ch.data;
					default: ;
				endcase
			end
			if (state_q == ST_POS && out_free) begin
				ovalid_q <= 1'b1;
			end else if (out_ch.ready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: if (in_fire) begin
					prev_r_q <= in_ch.right_count;
					prev_l_q <= in_ch.left_count;
					prev_s_q <= in_ch.side_count;
				end
				ST_HSUM: begin
					head_q <= nhead;
					step_q <= '0;
				end
				ST_CORD: step_q <= step_q + 1'b1;
				ST_POS: if (out_free) begin
					x_q      <= satx[31:0];
					y_q      <= saty[31:0];
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				dr_q <= in_ch.right_count - prev_r_q;
				dl_q <= in_ch.left_count - prev_l_q;
				ds_q <= in_ch.side_count - prev_s_q;
			end
			ST_ML: rt_q <= neg_prod[65:16];
			ST_MS: lt_q <= neg_prod[65:16];
			ST_TRAV: begin
				a_q    <= sata[31:0];
				s_q    <= sats[31:0];
				diff_q <= 64'(tdiff);
			end
			ST_H1: hstep_q <= prod_q[63:32];
			ST_H2: hstep_q <= hstep_q + prod_q[31:0];
			ST_HSUM: begin
				cx_q <= CORDIC_K;
				cy_q <= '0;
				// fold headings past a quarter turn by a half turn
				if (nhead_s > 32'sd1073741824 || nhead_s < -32'sd1073741824) begin
					z_q    <= 34'(signed'(fold));
					flip_q <= 1'b1;
				end else begin
					z_q    <= 34'(nhead_s);
					flip_q <= 1'b0;
				end
			end
			ST_CORD: begin
				if (!z_q[33]) begin
					cx_q <= cx_q - ysh;
					cy_q <= cy_q + xsh;
					z_q  <= z_q - atv;
				end else begin
					cx_q <= cx_q + ysh;
					cy_q <= cy_q - xsh;
					z_q  <= z_q + atv;
				end
			end
			ST_FLIP: begin
				c_q  <= flip_q ? 33'(-cx_q) : cx_q[32:0];
				sn_q <= flip_q ? 33'(-cy_q) : cy_q[32:0];
			end
			ST_P1: acc_q <= 67'(prod_q);
			ST_P2: dxs_q <= acc_q + 67'(prod_q);
			ST_P3: acc_q <= 67'(prod_q);
			ST_P4: acc_q <= acc_q - 67'(prod_q);
			ST_POS: if (out_free) begin
				ox_q    <= satx[31:0];
				oy_q    <= saty[31:0];
				oang_q  <= head_q;
				oclip_q <= satx[32] | saty[32];
			end
			default: ;
		endcase
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> state_q == ST_IDLE)
		else $error("input ready outside idle");
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CORD |-> step_q <= StepW'(CORDIC_STEPS - 1))
		else $error("cordic step out of range");
	a_out_after_pos: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ovalid_q) |-> $past(state_q) == ST_POS)
		else $error("result without position update");
	a_clip_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(ovalid_q && oclip_q) |-> (ox_q == 32'h7FFF_FFFF || ox_q == 32'h8000_0000
		|| oy_q == 32'h7FFF_FFFF || oy_q == 32'h8000_0000))
		else $error("clipped flag without limit value");

endmodule
